// ===== hdl/mcmp_pkg.sv =====
`default_nettype none

package mcmp_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned DATA_W = 7;
    localparam int unsigned CHAN_W = 4;
    localparam int unsigned KIND_W = 2;

    // Output tdata: channel, first_data, second_data packed and padded to bytes.
    localparam int unsigned OUT_PAYLOAD_W = CHAN_W + 2 * DATA_W;
    localparam int unsigned OUT_TDATA_W   = ((OUT_PAYLOAD_W + 7) / 8) * 8;

    // Upper nibble of a channel status byte.
    localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
    localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
    localparam logic [3:0] STAT_CTRL_CHG = 4'hB;
    localparam logic [3:0] STAT_SYSTEM   = 4'hF;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_ON  = 2'd0,
        KIND_NOTE_OFF = 2'd1,
        KIND_CTRL_CHG = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic              valid;
        t_event_kind       kind;
        logic [CHAN_W-1:0] channel;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
    } t_event;

endpackage

`default_nettype wire

// ===== hdl/mcmp_decoder.sv =====
`default_nettype none

module mcmp_decoder (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_fire,
    input  wire logic [mcmp_pkg::BYTE_W-1:0] i_byte,
    output mcmp_pkg::t_event                 o_event
);
    import mcmp_pkg::*;

    logic [BYTE_W-1:0] r_status, n_status;
    logic [DATA_W-1:0] r_held, n_held;
    logic              r_held_valid, n_held_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status     <= '0;
            r_held       <= '0;
            r_held_valid <= 1'b0;
        end else if (i_fire) begin
            r_status     <= n_status;
            r_held       <= n_held;
            r_held_valid <= n_held_valid;
        end
    end

    always_comb begin
        n_status           = r_status;
        n_held             = r_held;
        n_held_valid       = r_held_valid;
        o_event.valid      = 1'b0;
        o_event.kind       = KIND_NOTE_ON;
        o_event.channel    = r_status[CHAN_W-1:0];
        o_event.first_data = r_held;
        o_event.second_data = i_byte[DATA_W-1:0];

        if (i_byte[BYTE_W-1]) begin
            if (i_byte[7:4] == STAT_SYSTEM) begin
                // System bytes cancel running status but keep the held data.
                n_status = '0;
            end else begin
                n_status     = i_byte;
                n_held       = '0;
                n_held_valid = 1'b0;
            end
        end else if (!r_held_valid) begin
            n_held       = i_byte[DATA_W-1:0];
            n_held_valid = 1'b1;
        end else begin
            case (r_status[7:4])
                STAT_NOTE_ON: begin
                    o_event.valid = 1'b1;
                    // A note-on with zero velocity means note-off.
                    o_event.kind  = (i_byte[DATA_W-1:0] != '0) ? KIND_NOTE_ON
                                                               : KIND_NOTE_OFF;
                end
                STAT_NOTE_OFF: begin
                    o_event.valid = 1'b1;
                    o_event.kind  = KIND_NOTE_OFF;
                end
                STAT_CTRL_CHG: begin
                    o_event.valid = 1'b1;
                    o_event.kind  = KIND_CTRL_CHG;
                end
                default: begin
                    o_event.valid = 1'b0;
                end
            endcase
            if (o_event.valid) begin
                n_held       = '0;
                n_held_valid = 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/midi_channel_message_parser.sv =====
// A byte accepted into the input register is decoded combinationally from it, and its
// event is registered in the output register when the decoder consumes the byte.
// Throughput: one byte per cycle; the input side stalls only while the output register
// holds an event that the sink has not taken.
// Reset: synchronous, active low; clears running status, the held data byte and all
// valid flags.
`default_nettype none

module midi_channel_message_parser (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // Input stream, one received MIDI byte per transaction.
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [mcmp_pkg::BYTE_W-1:0]      i_s_axis_tdata,  // [7:0] midi_byte
    // Output stream, one channel event per transaction.
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    output logic [mcmp_pkg::OUT_TDATA_W-1:0]      o_m_axis_tdata,  // [3:0] channel,
                                                                   // [10:4] first_data,
                                                                   // [17:11] second_data,
                                                                   // [23:18] zero
    output logic [mcmp_pkg::KIND_W-1:0]           o_m_axis_tuser   // [1:0] event_kind
);
    import mcmp_pkg::*;

    // Input register stage.
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // Output register stage.
    logic              r_out_valid;
    t_event            r_out_event;

    logic   out_free;
    logic   fire;
    logic   in_ready;
    t_event dec_event;

    // The output register can take a new event when empty or being drained this cycle.
    assign out_free = !r_out_valid || i_m_axis_tready;
    // The decoder consumes the registered byte whenever its result has somewhere to go.
    assign fire     = r_in_valid && out_free;
    // The input register refills when empty or when its byte is consumed this cycle.
    assign in_ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_axis_tvalid) begin
            r_in_byte <= i_s_axis_tdata;
        end
    end

    mcmp_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_event (dec_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= fire && dec_event.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && dec_event.valid) begin
            r_out_event <= dec_event;
        end
    end

    assign o_s_axis_tready = in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_event.kind;
    assign o_m_axis_tdata  = {{(OUT_TDATA_W - OUT_PAYLOAD_W){1'b0}},
                              r_out_event.second_data,
                              r_out_event.first_data,
                              r_out_event.channel};

endmodule

`default_nettype wire

// ===== sim/midi_channel_message_parser_tb.sv =====
`timescale 1ns / 1ps

module midi_channel_message_parser_tb;

    import mcmp_pkg::*;

    // Idle cycles without any transaction on either side before the run is declared hung.
    // The long sink hold-off, HOLD_CYCLES, is far below this limit, so this leaves ample margin.
    localparam int unsigned HANG_LIMIT   = 4000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned BYTE_TARGET  = 1100;
    localparam int unsigned SETTLE_TICKS = 10;

    // One channel event as it leaves the block.
    typedef struct {
        t_event_kind       kind;
        logic [CHAN_W-1:0] channel;
        logic [DATA_W-1:0] first_data;
        logic [DATA_W-1:0] second_data;
    } chan_event_t;

    // Tracks the parser state on its own and keeps the events that the accepted bytes
    // must produce, oldest first.
    class channel_event_tracker;
        logic [BYTE_W-1:0] run_status;
        logic [DATA_W-1:0] first_byte;
        logic              first_held;
        chan_event_t       pending_events[$];
        int unsigned       errors;

        function new();
            run_status = '0;
            first_byte = '0;
            first_held = 1'b0;
            errors     = 0;
        endfunction

        function int unsigned pending();
            return pending_events.size();
        endfunction

        // Applies one accepted input byte to the running-status state.
        function void take_byte(logic [BYTE_W-1:0] b);
            chan_event_t ev;
            bit          fires;
            if (b[7]) begin
                // System bytes, real-time included, only cancel the running status.
                if (b[7:4] == STAT_SYSTEM) begin
                    run_status = '0;
                end else begin
                    run_status = b;
                    first_byte = '0;
                    first_held = 1'b0;
                end
                return;
            end
            if (!first_held) begin
                first_byte = b[DATA_W-1:0];
                first_held = 1'b1;
                return;
            end
            // A second data byte: only note and controller statuses turn it into an event.
            fires = 1'b1;
            case (run_status[7:4])
                STAT_NOTE_ON: begin
                    ev.kind = (b[DATA_W-1:0] != '0) ? KIND_NOTE_ON : KIND_NOTE_OFF;
                end
                STAT_NOTE_OFF: begin
                    ev.kind = KIND_NOTE_OFF;
                end
                STAT_CTRL_CHG: begin
                    ev.kind = KIND_CTRL_CHG;
                end
                default: begin
                    fires   = 1'b0;
                    ev.kind = KIND_NOTE_ON;
                end
            endcase
            if (fires) begin
                ev.channel     = run_status[3:0];
                ev.first_data  = first_byte;
                ev.second_data = b[DATA_W-1:0];
                pending_events.push_back(ev);
                first_byte = '0;
                first_held = 1'b0;
            end
        endfunction

        // Compares one event taken from the output stream against the oldest expectation.
        function void compare_event(logic [KIND_W-1:0] kind,
                                    logic [OUT_TDATA_W-1:0] data);
            chan_event_t want;
            if (pending_events.size() == 0) begin
                $error("Unexpected event: kind %0d tdata 0x%06h", kind, data);
                errors++;
                return;
            end
            want = pending_events.pop_front();
            if (kind !== want.kind) begin
                $error("event_kind expected %0d actual %0d", want.kind, kind);
                errors++;
            end
            if (data[3:0] !== want.channel) begin
                $error("channel expected %0d actual %0d", want.channel, data[3:0]);
                errors++;
            end
            if (data[10:4] !== want.first_data) begin
                $error("first_data expected %0d actual %0d", want.first_data, data[10:4]);
                errors++;
            end
            if (data[17:11] !== want.second_data) begin
                $error("second_data expected %0d actual %0d", want.second_data, data[17:11]);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_s_axis_tvalid = 1'b0;
    logic                    o_s_axis_tready;
    logic [BYTE_W-1:0]       i_s_axis_tdata = '0;       // [7:0] midi_byte
    logic                    o_m_axis_tvalid;
    logic                    i_m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]  o_m_axis_tdata;            // [3:0] channel, [10:4] first_data,
                                                        // [17:11] second_data, [23:18] zero
    logic [KIND_W-1:0]       o_m_axis_tuser;            // [1:0] event_kind

    channel_event_tracker tracker = new();

    int unsigned bytes_sent    = 0;
    int unsigned burst_left    = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served   = 0;
    int unsigned hold_left     = 0;
    int unsigned sink_phase    = 0;
    int unsigned sink_mode     = 0;
    int unsigned quiet_cycles  = 0;

    midi_channel_message_parser dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both streams are observed at the rising edge, where the block samples them too.
    // Every accepted byte updates the predicted state, every accepted event is checked.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                tracker.take_byte(i_s_axis_tdata);
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                tracker.compare_event(o_m_axis_tuser, o_m_axis_tdata);
            end
        end
    end

    // Watchdog: a run where no transaction happens for too long is considered hung.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= HANG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // The sink alternates between always-ready stretches and stretches with random stalls.
    // When the stimulus asks for it, the sink refuses events for a long counted hold-off,
    // so the output register fills and the block has to stall its input side.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            i_m_axis_tready = 1'b0;
            hold_left--;
        end else if (hold_served != hold_requests) begin
            hold_served++;
            hold_left       = HOLD_CYCLES - 1;
            i_m_axis_tready = 1'b0;
        end else begin
            if (sink_phase == 0) begin
                sink_mode  = $urandom_range(0, 2);
                sink_phase = $urandom_range(16, 96);
            end
            sink_phase--;
            case (sink_mode)
                0: begin
                    i_m_axis_tready = 1'b1;
                end
                1: begin
                    i_m_axis_tready = 1'($urandom_range(0, 1));
                end
                default: begin
                    i_m_axis_tready = ($urandom_range(0, 3) == 0);
                end
            endcase
        end
    end

    // Offers one byte and returns once the transaction has completed. Bytes go out in
    // bursts of random length; between bursts tvalid drops for a random number of cycles.
    // Some bursts are long, which gives stretches with no source idling at all.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (burst_left == 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, 5)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        burst_left--;
        bytes_sent++;
    endtask

    // Stops offering bytes until every predicted event has been taken from the block.
    task automatic drain_events();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        burst_left      = 0;
        while (tracker.pending() != 0) @(posedge i_clk);
    endtask

    // A well-formed channel message with random content. The status byte is sometimes
    // left out to exercise running status, note-on with velocity zero shows up often,
    // and now and then a real-time byte lands in the middle of the message.
    task automatic send_message();
        logic [3:0]        nibble;
        logic [BYTE_W-1:0] rt_byte;
        logic [DATA_W-1:0] second;
        int unsigned       pick;
        pick = $urandom_range(0, 2);
        nibble = (pick == 0) ? STAT_NOTE_OFF : (pick == 1) ? STAT_NOTE_ON : STAT_CTRL_CHG;
        rt_byte = {STAT_SYSTEM, 1'b1, 3'($urandom_range(0, 7))};
        second = ($urandom_range(0, 6) == 0) ? '0 : DATA_W'($urandom_range(0, 127));
        if ($urandom_range(0, 2) != 0 || tracker.run_status == '0) begin
            send_byte({nibble, 4'($urandom_range(0, 15))});
        end
        send_byte({1'b0, DATA_W'($urandom_range(0, 127))});
        if ($urandom_range(0, 19) == 0) begin
            send_byte(rt_byte);
        end
        send_byte({1'b0, second});
    endtask

    // A status that never yields events (or a system common byte), followed by up to
    // three data bytes. These leave the parser in states that a clean stream never reaches.
    task automatic send_broken();
        logic [BYTE_W-1:0] status;
        int unsigned       pick;
        pick = $urandom_range(0, 4);
        case (pick)
            0: status = {4'hA, 4'($urandom_range(0, 15))};
            1: status = {4'hC, 4'($urandom_range(0, 15))};
            2: status = {4'hD, 4'($urandom_range(0, 15))};
            3: status = {4'hE, 4'($urandom_range(0, 15))};
            default: status = {STAT_SYSTEM, 1'b0, 3'($urandom_range(0, 7))};
        endcase
        send_byte(status);
        repeat ($urandom_range(0, 3)) send_byte({1'b0, DATA_W'($urandom_range(0, 127))});
    endtask

    initial begin
        logic [BYTE_W-1:0] opening[$];
        bit hold_done;
        bit pause_done;
        int unsigned roll;

        // Directed opening: data before any status, note zero with full and zero velocity,
        // note-off on channel 15, a controller with number zero, a real-time byte in the
        // middle of a message, statuses that give no event, and the byte range extremes.
        opening = '{
            8'h00, 8'h7F,
            8'h90, 8'h00, 8'h7F,
            8'h00, 8'h00,
            8'h8F, 8'h3C, 8'h40,
            8'hBA, 8'h00, 8'h7F,
            8'h07, 8'hF8, 8'h11,
            8'hE3, 8'h01, 8'h02,
            8'hF0, 8'hFF, 8'hEF, 8'hC5, 8'h12, 8'h80
        };
        hold_done  = 1'b0;
        pause_done = 1'b0;

        // Reset is held from time zero and released on a falling edge.
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (opening[k]) begin
            send_byte(opening[k]);
        end

        while (bytes_sent < BYTE_TARGET) begin
            // Around a third of the way in, the sink goes quiet while bytes keep coming.
            if (!hold_done && bytes_sent >= 400) begin
                hold_requests++;
                hold_done = 1'b1;
            end
            // Later on, the source waits for the block to empty out completely.
            if (!pause_done && bytes_sent >= 750) begin
                drain_events();
                pause_done = 1'b1;
            end
            roll = $urandom_range(0, 99);
            if (roll < 78) begin
                send_message();
            end else if (roll < 90) begin
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end else begin
                send_broken();
            end
        end

        drain_events();
        repeat (SETTLE_TICKS) @(posedge i_clk);

        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
